@@ hw/rtl/pssq_pkg.sv @@
package pssq_pkg;

    localparam int unsigned TickWidth = 24;
    localparam logic [TickWidth-1:0] TickMax = '1;

    // opcodes of an input beat
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_POLL  = 3'd1;
    localparam logic [2:0] OP_ID    = 3'd2;
    localparam logic [2:0] OP_TEMP  = 3'd3;
    localparam logic [2:0] OP_PRESS = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_LOCKUP     = 2'd0;
    localparam logic [1:0] CFG_TEMP_WAIT  = 2'd1;
    localparam logic [1:0] CFG_PRESS_WAIT = 2'd2;

    localparam logic [TickWidth-1:0] LOCKUP_RESET     = 24'd1000;
    localparam logic [TickWidth-1:0] TEMP_WAIT_RESET  = 24'd5;
    localparam logic [TickWidth-1:0] PRESS_WAIT_RESET = 24'd30;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_BUSY   = 2'd1;
    localparam logic [1:0] ERR_LOCKUP = 2'd2;
    localparam logic [1:0] ERR_BAD_ID = 2'd3;

    // bus and sensor constants
    localparam logic [7:0] ADDR_WR    = 8'hee;
    localparam logic [7:0] ADDR_RD    = 8'hef;
    localparam logic [7:0] CMD_TEMP   = 8'h2e;
    localparam logic [7:0] CMD_PRESS3 = 8'hf4;
    localparam logic [7:0] REG_ID     = 8'hd0;
    localparam logic [7:0] REG_CTRL   = 8'hf4;
    localparam logic [7:0] REG_CALIB  = 8'haa;
    localparam logic [7:0] REG_RESULT = 8'hf6;
    localparam logic [7:0] CHIP_ID    = 8'h55;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ID_W   = 4'd1,
        PH_ID_R   = 4'd2,
        PH_CAL_W  = 4'd3,
        PH_CAL_R  = 4'd4,
        PH_T_CONV = 4'd5,
        PH_T_W    = 4'd6,
        PH_T_R    = 4'd7,
        PH_P_CONV = 4'd8,
        PH_P_W    = 4'd9,
        PH_P_R    = 4'd10
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [TickWidth-1:0]  elapsed;
        logic                  halted;
    } seq_state_t;

    typedef struct packed {
        logic [TickWidth-1:0] lockup;
        logic [TickWidth-1:0] temp_wait;
        logic [TickWidth-1:0] press_wait;
    } seq_cfg_t;

    typedef struct packed {
        logic       ready_res;
        logic       start_xfer;
        logic [7:0] bus_address;
        logic [4:0] xfer_length;
        logic [7:0] tx_byte_zero;
        logic [7:0] tx_byte_one;
        logic [1:0] error_code;
    } seq_result_t;

endpackage

@@ hw/rtl/pressure_sensor_read_sequencer_core.sv @@
// Bus transaction sequencer for a barometric pressure sensor. Each input beat is one
// event (tick, poll of the transfer engine, or a request for ID plus calibration,
// temperature or pressure) and gives exactly one result beat carrying a ready flag,
// an optional transfer order and an error code. Any error (busy, lockup, bad chip ID)
// halts the sequencer until reset. Beats pass through an input register and a result
// register with one step of phase logic between them, so one beat is taken every
// cycle while the result side keeps up. Configuration registers are to be written
// through the cfg port only while no beat is in flight; the user must keep to this,
// as the block does not enforce it. cfg_ready is always high.
module pressure_sensor_read_sequencer_core
    import pssq_pkg::*;
#(
    parameter int unsigned CALIB_BYTES = 22
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic        s_bus_idle,
    input  logic [7:0]  s_rx_first_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ready_res,
    output logic        m_start_xfer,
    output logic [7:0]  m_bus_address,
    output logic [4:0]  m_xfer_length,
    output logic [7:0]  m_tx_byte_zero,
    output logic [7:0]  m_tx_byte_one,
    output logic [1:0]  m_error_code
);

    seq_cfg_t    cfg_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_result_t result_next;
    seq_result_t result_reg;

    logic        in_valid_reg;
    logic [2:0]  opcode_reg;
    logic        bus_idle_reg;
    logic [7:0]  rx_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        s_beat;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_beat    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lockup     <= LOCKUP_RESET;
            cfg_reg.temp_wait  <= TEMP_WAIT_RESET;
            cfg_reg.press_wait <= PRESS_WAIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOCKUP:     cfg_reg.lockup     <= cfg_data;
                CFG_TEMP_WAIT:  cfg_reg.temp_wait  <= cfg_data;
                CFG_PRESS_WAIT: cfg_reg.press_wait <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_beat) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            opcode_reg   <= s_opcode;
            bus_idle_reg <= s_bus_idle;
            rx_reg       <= s_rx_first_byte;
        end
    end

    pssq_step #(
        .CALIB_BYTES (CALIB_BYTES)
    ) u_step (
        .opcode        (opcode_reg),
        .bus_idle      (bus_idle_reg),
        .rx_first_byte (rx_reg),
        .cfg           (cfg_reg),
        .state         (state_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    // sequencer state moves once per beat handed to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase   <= PH_IDLE;
            state_reg.elapsed <= '0;
            state_reg.halted  <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_ready_res    = result_reg.ready_res;
    assign m_start_xfer   = result_reg.start_xfer;
    assign m_bus_address  = result_reg.bus_address;
    assign m_xfer_length  = result_reg.xfer_length;
    assign m_tx_byte_zero = result_reg.tx_byte_zero;
    assign m_tx_byte_one  = result_reg.tx_byte_one;
    assign m_error_code   = result_reg.error_code;

endmodule

@@ hw/rtl/pssq_step.sv @@
module pssq_step
    import pssq_pkg::*;
#(
    parameter int unsigned CALIB_BYTES = 22
) (
    input  logic [2:0]  opcode,
    input  logic        bus_idle,
    input  logic [7:0]  rx_first_byte,
    input  seq_cfg_t    cfg,
    input  seq_state_t  state,
    output seq_state_t  state_next,
    output seq_result_t result
);

    // length field is five bits wide, so a full 32-byte table wraps to zero
    localparam logic [4:0] CalibLen = 5'(CALIB_BYTES % 32);

    logic is_request;
    logic lockup_hit;

    assign is_request = (opcode == OP_ID) || (opcode == OP_TEMP) || (opcode == OP_PRESS);
    assign lockup_hit = state.elapsed > cfg.lockup;

    // next state
    always_comb begin
        state_next = state;
        if (!state.halted) begin
            if (opcode == OP_TICK) begin
                if (state.elapsed != TickMax) begin
                    state_next.elapsed = state.elapsed + 1'b1;
                end
            end else if (is_request) begin
                if (state.phase != PH_IDLE) begin
                    state_next.halted = 1'b1;
                end else begin
                    state_next.elapsed = '0;
                    case (opcode)
                        OP_ID:   state_next.phase = PH_ID_W;
                        OP_TEMP: state_next.phase = PH_T_CONV;
                        default: state_next.phase = PH_P_CONV;
                    endcase
                end
            end else if (opcode == OP_POLL && state.phase != PH_IDLE) begin
                if (lockup_hit) begin
                    state_next.halted = 1'b1;
                end else if (bus_idle) begin
                    case (state.phase)
                        PH_ID_W: state_next.phase = PH_ID_R;
                        PH_ID_R: begin
                            if (rx_first_byte != CHIP_ID) begin
                                state_next.halted = 1'b1;
                            end else begin
                                state_next.phase = PH_CAL_W;
                            end
                        end
                        PH_CAL_W: state_next.phase = PH_CAL_R;
                        PH_T_CONV: begin
                            if (state.elapsed > cfg.temp_wait) begin
                                state_next.phase = PH_T_W;
                            end
                        end
                        PH_T_W: state_next.phase = PH_T_R;
                        PH_P_CONV: begin
                            if (state.elapsed > cfg.press_wait) begin
                                state_next.phase = PH_P_W;
                            end
                        end
                        PH_P_W:  state_next.phase = PH_P_R;
                        default: state_next.phase = PH_IDLE;
                    endcase
                end
            end
        end
    end

    // result beat
    always_comb begin
        result = '0;
        if (!state.halted) begin
            if (is_request) begin
                if (state.phase != PH_IDLE) begin
                    result.error_code = ERR_BUSY;
                end else begin
                    result.start_xfer  = 1'b1;
                    result.bus_address = ADDR_WR;
                    case (opcode)
                        OP_ID: begin
                            result.xfer_length  = 5'd1;
                            result.tx_byte_zero = REG_ID;
                        end
                        OP_TEMP: begin
                            result.xfer_length  = 5'd2;
                            result.tx_byte_zero = REG_CTRL;
                            result.tx_byte_one  = CMD_TEMP;
                        end
                        default: begin
                            result.xfer_length  = 5'd2;
                            result.tx_byte_zero = REG_CTRL;
                            result.tx_byte_one  = CMD_PRESS3;
                        end
                    endcase
                end
            end else if (opcode == OP_POLL) begin
                if (state.phase == PH_IDLE) begin
                    result.ready_res = 1'b1;
                end else if (lockup_hit) begin
                    result.error_code = ERR_LOCKUP;
                end else if (bus_idle) begin
                    case (state.phase)
                        PH_ID_W: begin
                            result.start_xfer  = 1'b1;
                            result.bus_address = ADDR_RD;
                            result.xfer_length = 5'd1;
                        end
                        PH_ID_R: begin
                            if (rx_first_byte != CHIP_ID) begin
                                result.error_code = ERR_BAD_ID;
                            end else begin
                                result.start_xfer   = 1'b1;
                                result.bus_address  = ADDR_WR;
                                result.xfer_length  = 5'd1;
                                result.tx_byte_zero = REG_CALIB;
                            end
                        end
                        PH_CAL_W: begin
                            result.start_xfer  = 1'b1;
                            result.bus_address = ADDR_RD;
                            result.xfer_length = CalibLen;
                        end
                        PH_T_CONV: begin
                            if (state.elapsed > cfg.temp_wait) begin
                                result.start_xfer   = 1'b1;
                                result.bus_address  = ADDR_WR;
                                result.xfer_length  = 5'd1;
                                result.tx_byte_zero = REG_RESULT;
                            end
                        end
                        PH_T_W: begin
                            result.start_xfer  = 1'b1;
                            result.bus_address = ADDR_RD;
                            result.xfer_length = 5'd2;
                        end
                        PH_P_CONV: begin
                            if (state.elapsed > cfg.press_wait) begin
                                result.start_xfer   = 1'b1;
                                result.bus_address  = ADDR_WR;
                                result.xfer_length  = 5'd1;
                                result.tx_byte_zero = REG_RESULT;
                            end
                        end
                        PH_P_W: begin
                            result.start_xfer  = 1'b1;
                            result.bus_address = ADDR_RD;
                            result.xfer_length = 5'd3;
                        end
                        default: result = '0;
                    endcase
                end
            end
        end
    end

endmodule

@@ bench/tb_pressure_sensor_read_sequencer_core.sv @@
`timescale 1ns / 100ps

module tb_pressure_sensor_read_sequencer_core;
    import pssq_pkg::*;

    localparam int          CalibBytes  = 22;
    localparam int          DrainCycles = 8;
    localparam int          HoldCycles  = 400;
    localparam int          CycleLimit  = 500000;
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;
    localparam logic [2:0]  OP_SPARE5   = 3'd5;
    localparam logic [2:0]  OP_SPARE6   = 3'd6;
    localparam logic [2:0]  OP_SPARE7   = 3'd7;

    class seq_scoreboard;
        seq_cfg_t             cfg;
        phase_t               phase;
        logic [TickWidth-1:0] elapsed;
        bit                   halted;
        seq_result_t          expected_q[$];
        int unsigned          mismatches;

        function new();
            cfg.lockup     = LOCKUP_RESET;
            cfg.temp_wait  = TEMP_WAIT_RESET;
            cfg.press_wait = PRESS_WAIT_RESET;
            phase          = PH_IDLE;
            elapsed        = '0;
            halted         = 1'b0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [TickWidth-1:0] data);
            case (index)
                CFG_LOCKUP:     cfg.lockup = data;
                CFG_TEMP_WAIT:  cfg.temp_wait = data;
                CFG_PRESS_WAIT: cfg.press_wait = data;
                default: ;
            endcase
        endfunction

        function seq_result_t xfer(logic [7:0] addr, logic [4:0] len, logic [7:0] b0,
                                   logic [7:0] b1);
            seq_result_t r;
            r              = '0;
            r.start_xfer   = 1'b1;
            r.bus_address  = addr;
            r.xfer_length  = len;
            r.tx_byte_zero = b0;
            r.tx_byte_one  = b1;
            return r;
        endfunction

        // advance the sequencer by one accepted input beat
        function void note_event(logic [2:0] op, logic bus_idle, logic [7:0] rx);
            seq_result_t r;
            r = '0;
            if (!halted) begin
                case (op)
                    OP_TICK: begin
                        if (elapsed != TickMax) elapsed = elapsed + 1'b1;
                    end
                    OP_ID, OP_TEMP, OP_PRESS: begin
                        if (phase != PH_IDLE) begin
                            r.error_code = ERR_BUSY;
                            halted       = 1'b1;
                        end else begin
                            elapsed = '0;
                            case (op)
                                OP_ID: begin
                                    r     = xfer(ADDR_WR, 5'd1, REG_ID, 8'h00);
                                    phase = PH_ID_W;
                                end
                                OP_TEMP: begin
                                    r     = xfer(ADDR_WR, 5'd2, REG_CTRL, CMD_TEMP);
                                    phase = PH_T_CONV;
                                end
                                default: begin
                                    r     = xfer(ADDR_WR, 5'd2, REG_CTRL, CMD_PRESS3);
                                    phase = PH_P_CONV;
                                end
                            endcase
                        end
                    end
                    OP_POLL: begin
                        // lockup is checked before the bus state
                        if (phase == PH_IDLE) begin
                            r.ready_res = 1'b1;
                        end else if (elapsed > cfg.lockup) begin
                            r.error_code = ERR_LOCKUP;
                            halted       = 1'b1;
                        end else if (bus_idle) begin
                            case (phase)
                                PH_ID_W: begin
                                    r     = xfer(ADDR_RD, 5'd1, 8'h00, 8'h00);
                                    phase = PH_ID_R;
                                end
                                PH_ID_R: begin
                                    if (rx != CHIP_ID) begin
                                        r.error_code = ERR_BAD_ID;
                                        halted       = 1'b1;
                                    end else begin
                                        r     = xfer(ADDR_WR, 5'd1, REG_CALIB, 8'h00);
                                        phase = PH_CAL_W;
                                    end
                                end
                                PH_CAL_W: begin
                                    r     = xfer(ADDR_RD, 5'(CalibBytes), 8'h00, 8'h00);
                                    phase = PH_CAL_R;
                                end
                                PH_T_CONV: begin
                                    if (elapsed > cfg.temp_wait) begin
                                        r     = xfer(ADDR_WR, 5'd1, REG_RESULT, 8'h00);
                                        phase = PH_T_W;
                                    end
                                end
                                PH_T_W: begin
                                    r     = xfer(ADDR_RD, 5'd2, 8'h00, 8'h00);
                                    phase = PH_T_R;
                                end
                                PH_P_CONV: begin
                                    if (elapsed > cfg.press_wait) begin
                                        r     = xfer(ADDR_WR, 5'd1, REG_RESULT, 8'h00);
                                        phase = PH_P_W;
                                    end
                                end
                                PH_P_W: begin
                                    r     = xfer(ADDR_RD, 5'd3, 8'h00, 8'h00);
                                    phase = PH_P_R;
                                end
                                default: phase = PH_IDLE;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            expected_q.push_back(r);
        endfunction

        function string describe(seq_result_t r);
            return $sformatf("rdy=%0b start=%0b addr=%h len=%0d b0=%h b1=%h err=%0d",
                             r.ready_res, r.start_xfer, r.bus_address, r.xfer_length,
                             r.tx_byte_zero, r.tx_byte_one, r.error_code);
        endfunction

        function void check_result(seq_result_t got);
            seq_result_t want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result beat with nothing expected: %s", $time,
                             describe(got));
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    if (mismatches < 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                                 describe(want), describe(got));
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_opcode;
    logic        s_bus_idle;
    logic [7:0]  s_rx_first_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_ready_res;
    logic        m_start_xfer;
    logic [7:0]  m_bus_address;
    logic [4:0]  m_xfer_length;
    logic [7:0]  m_tx_byte_zero;
    logic [7:0]  m_tx_byte_one;
    logic [1:0]  m_error_code;

    seq_scoreboard sb = new();
    int            snd_idle_pct;
    int            rcv_idle_pct;
    bit            hold_request;
    int            cycle_count;

    pressure_sensor_read_sequencer_core #(
        .CALIB_BYTES(CalibBytes)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_bus_idle     (s_bus_idle),
        .s_rx_first_byte(s_rx_first_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ready_res    (m_ready_res),
        .m_start_xfer   (m_start_xfer),
        .m_bus_address  (m_bus_address),
        .m_xfer_length  (m_xfer_length),
        .m_tx_byte_zero (m_tx_byte_zero),
        .m_tx_byte_one  (m_tx_byte_one),
        .m_error_code   (m_error_code)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result({m_ready_res, m_start_xfer, m_bus_address, m_xfer_length,
                                 m_tx_byte_zero, m_tx_byte_one, m_error_code});
            if (hold_request && !hold_done) begin
                hold_left = HoldCycles;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_event(input logic [2:0] op, input logic bus_idle,
                              input logic [7:0] rx);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_bus_idle      <= bus_idle;
        s_rx_first_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(op, bus_idle, rx);
    endtask

    // index 3 is written too, the block must ignore it
    task automatic program_regs(input logic [23:0] lockup, input logic [23:0] temp_wait,
                                input logic [23:0] press_wait);
        logic [1:0]  idx [4];
        logic [23:0] val [4];
        idx = '{CFG_LOCKUP, CFG_TEMP_WAIT, CFG_PRESS_WAIT, CFG_UNUSED};
        val = '{lockup, temp_wait, press_wait, 24'($urandom)};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    function automatic bit wait_reachable(logic [23:0] wait_ticks);
        return (wait_ticks < sb.cfg.lockup) && (wait_ticks < 24'd200);
    endfunction

    // well-formed sequences with random content, never provoking an error
    function automatic void pick_event(output logic [2:0] op, output logic bus_idle,
                                       output logic [7:0] rx);
        int roll;
        bit tick_ok;
        bit waiting;
        roll     = $urandom_range(99);
        bus_idle = ($urandom_range(99) < 75);
        rx       = 8'($urandom_range(255));
        tick_ok  = (sb.phase == PH_IDLE) || (sb.elapsed < sb.cfg.lockup);
        waiting  = (sb.phase == PH_T_CONV && sb.elapsed <= sb.cfg.temp_wait) ||
                   (sb.phase == PH_P_CONV && sb.elapsed <= sb.cfg.press_wait);
        if (roll < 8) begin
            op = OP_SPARE5 + 3'($urandom_range(2));
        end else if (sb.phase == PH_IDLE) begin
            if (roll < 20) begin
                op = OP_TICK;
            end else if (roll < 30) begin
                op = OP_POLL;
            end else begin
                case ($urandom_range(2))
                    0: op = OP_ID;
                    1: op = wait_reachable(sb.cfg.temp_wait) ? OP_TEMP : OP_ID;
                    default: op = wait_reachable(sb.cfg.press_wait) ? OP_PRESS : OP_ID;
                endcase
            end
        end else if (tick_ok && ((waiting && roll < 85) || roll < 15)) begin
            op = OP_TICK;
        end else begin
            op = OP_POLL;
            if (sb.phase == PH_ID_R && bus_idle) rx = CHIP_ID;
        end
    endfunction

    task automatic run_random(input int n_events);
        int          counted;
        logic [2:0]  op;
        logic        bus_idle;
        logic [7:0]  rx;
        counted = 0;
        // carry on past the count until the pending sequence has finished
        while (counted < n_events || sb.phase != PH_IDLE) begin
            pick_event(op, bus_idle, rx);
            send_event(op, bus_idle, rx);
            if (op <= OP_PRESS) counted++;
        end
        settle();
    endtask

    initial begin : stimulus
        int          lk;
        logic [2:0]  req;
        logic [7:0]  bad_id;
        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_LOCKUP;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_opcode        <= OP_TICK;
        s_bus_idle      <= 1'b0;
        s_rx_first_byte <= 8'h00;
        hold_request    = 1'b0;
        snd_idle_pct    = 22;
        rcv_idle_pct    = 79;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, spare opcodes, full id and temperature runs
        send_event(OP_TICK, 1'b0, 8'h00);
        send_event(OP_TICK, 1'b1, 8'hff);
        send_event(OP_POLL, 1'b1, 8'hff);
        send_event(OP_SPARE5, 1'b0, 8'h00);
        send_event(OP_SPARE6, 1'b1, 8'hff);
        send_event(OP_SPARE7, 1'b1, 8'h5a);
        send_event(OP_ID, 1'b1, 8'ha5);
        send_event(OP_POLL, 1'b0, 8'hff);
        send_event(OP_POLL, 1'b1, 8'h00);
        send_event(OP_POLL, 1'b1, CHIP_ID);
        send_event(OP_POLL, 1'b1, 8'hff);
        send_event(OP_POLL, 1'b1, 8'h00);
        send_event(OP_TEMP, 1'b0, 8'h00);
        send_event(OP_POLL, 1'b1, 8'h00);
        repeat (6) send_event(OP_TICK, 1'b0, 8'h00);
        send_event(OP_POLL, 1'b1, 8'h00);
        send_event(OP_POLL, 1'b1, 8'h00);
        send_event(OP_POLL, 1'b1, 8'h00);
        send_event(OP_PRESS, 1'b1, 8'hff);
        send_event(OP_POLL, 1'b1, 8'h00);

        run_random(330);
        program_regs(24'd1, 24'd0, 24'd0);
        run_random(330);

        snd_idle_pct = 79;
        rcv_idle_pct = 22;
        program_regs(TickMax, TickMax, TickMax);
        run_random(330);
        lk = $urandom_range(300, 4);
        program_regs(24'(lk), 24'($urandom_range(lk - 1, 0)), 24'($urandom_range(lk - 1, 0)));
        run_random(330);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        lk = $urandom_range(300, 4);
        program_regs(24'(lk), 24'($urandom_range(lk - 1, 0)), 24'($urandom_range(lk - 1, 0)));
        hold_request = 1'b1;
        run_random(340);
        program_regs(TickMax, 24'd0, 24'd0);
        run_random(340);

        // one error per run, as only reset clears the halt
        program_regs(24'd2, 24'($urandom_range(200)), 24'($urandom_range(200)));
        req = OP_ID + 3'($urandom_range(2));
        case ($urandom_range(2))
            0: begin
                send_event(req, 1'($urandom), 8'($urandom));
                send_event(OP_ID + 3'($urandom_range(2)), 1'($urandom), 8'($urandom));
            end
            1: begin
                send_event(req, 1'b1, 8'h00);
                repeat (3) send_event(OP_TICK, 1'b0, 8'h00);
                send_event(OP_POLL, 1'($urandom), 8'($urandom));
            end
            default: begin
                do bad_id = 8'($urandom); while (bad_id == CHIP_ID);
                send_event(OP_ID, 1'b1, 8'h00);
                send_event(OP_POLL, 1'b1, 8'h00);
                send_event(OP_POLL, 1'b1, bad_id);
            end
        endcase
        // halted: every beat gives an all-zero result
        repeat (20) send_event(3'($urandom_range(7)), 1'($urandom), 8'($urandom));
        settle();

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
